// ===== design/apll_pkg.sv =====
// ----------------------------------------------------------------------------
// apll_pkg
// shared types, constants and helper functions of the analog pll register block
// ----------------------------------------------------------------------------
`default_nettype none

package apll_pkg;

  // register file geometry
  localparam int REG_COUNT = 256;
  localparam int IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // fixed locations in the aperture
  localparam logic [11:0] ID_OFFSET   = 12'h260;
  localparam logic [11:0] ZERO_OFFSET = 12'h280;
  localparam logic [31:0] ID_VALUE    = 32'h0061_0001;
  localparam logic [31:0] LOCK_BIT    = 32'h8000_0000;

  // command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // access size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // alias codes, word offset within a 16-byte group
  localparam logic [1:0] ALIAS_WRITE  = 2'd0;
  localparam logic [1:0] ALIAS_SET    = 2'd1;
  localparam logic [1:0] ALIAS_CLEAR  = 2'd2;
  localparam logic [1:0] ALIAS_TOGGLE = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [11:0] offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
  } rsp_t;

  // register file write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      data;
  } wr_t;

  // group index, wrapped to the register count
  function automatic logic [IDX_W-1:0] slot_of(input logic [11:0] off);
    int grp;
    grp = int'(off[11:4]);
    return IDX_W'(grp % REG_COUNT);
  endfunction

  // power-on contents of a register
  function automatic logic [31:0] reset_value(input logic [IDX_W-1:0] idx);
    logic [31:0] v;
    case (int'(idx))
      'h00:    v = 32'h8000_2042;
      'h01:    v = 32'h8000_3000;
      'h02:    v = 32'h8000_3000;
      'h03:    v = 32'h8000_2001;
      'h07:    v = 32'h0001_1006;
      'h08:    v = 32'h05F5_E100;
      'h09:    v = 32'h2964_619C;
      'h0A:    v = 32'h0001_100C;
      'h0B:    v = 32'h05F5_E100;
      'h0C:    v = 32'h2964_619C;
      'h0E:    v = 32'h8000_2001;
      'h0F:    v = 32'h1311_100C;
      'h10:    v = 32'h1018_101B;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  // pll groups keep their lock bit set on every write
  function automatic logic is_pll_group(input logic [11:0] off);
    logic [7:0] grp;
    grp = off[11:4];
    return grp inside {8'h00, 8'h01, 8'h02, 8'h03, 8'h0E};
  endfunction

endpackage

`default_nettype wire

// ===== design/apll_ram.sv =====
// ----------------------------------------------------------------------------
// apll_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module apll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/apll_alu.sv =====
// ----------------------------------------------------------------------------
// apll_alu
// access decode, sub-word merge, alias operation and read formatting
// ----------------------------------------------------------------------------
`default_nettype none

module apll_alu (
  input  wire apll_pkg::req_t      req,
  input  wire logic [31:0]         cur_word,
  output apll_pkg::rsp_t           rsp,
  output apll_pkg::wr_t            wr
);

  logic [11:0] aligned;
  logic        is_special;
  logic [31:0] word_rd;
  logic        is_word;
  logic        misaligned;
  logic [4:0]  byte_shift;
  logic [4:0]  half_shift;
  logic [31:0] mask;
  logic [31:0] merged;
  logic [31:0] wval;
  logic [31:0] alias_val;

  always_comb begin
    aligned    = {req.offset[11:2], 2'b00};
    is_special = (aligned == apll_pkg::ID_OFFSET) || (aligned == apll_pkg::ZERO_OFFSET);

    if (aligned == apll_pkg::ID_OFFSET) begin
      word_rd = apll_pkg::ID_VALUE;
    end else if (aligned == apll_pkg::ZERO_OFFSET) begin
      word_rd = 32'h0;
    end else begin
      word_rd = cur_word;
    end

    // size code three behaves as a word
    is_word    = req.access_size[1];
    misaligned = is_word && (req.offset[1:0] != 2'b00);
    byte_shift = {req.offset[1:0], 3'b000};
    half_shift = {req.offset[1], 4'b0000};

    // bits shifted past 31 drop off
    mask   = ((req.access_size == apll_pkg::SIZE_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF)
             << byte_shift;
    merged = (word_rd & ~mask) | ((req.write_data << byte_shift) & mask);
    wval   = is_word ? req.write_data : merged;

    case (req.offset[3:2])
      apll_pkg::ALIAS_WRITE:  alias_val = wval;
      apll_pkg::ALIAS_SET:    alias_val = cur_word | wval;
      apll_pkg::ALIAS_CLEAR:  alias_val = cur_word & ~wval;
      apll_pkg::ALIAS_TOGGLE: alias_val = cur_word ^ wval;
      default:                alias_val = wval;
    endcase
    if (apll_pkg::is_pll_group(req.offset)) begin
      alias_val = alias_val | apll_pkg::LOCK_BIT;
    end

    wr.en   = (req.cmd == apll_pkg::CMD_WRITE) && !is_special && !misaligned;
    wr.idx  = apll_pkg::slot_of(req.offset);
    wr.data = alias_val;

    rsp.access_error = misaligned;
    if (misaligned || (req.cmd == apll_pkg::CMD_WRITE)) begin
      rsp.read_data = 32'h0;
    end else if (is_word) begin
      rsp.read_data = word_rd;
    end else if (req.access_size == apll_pkg::SIZE_BYTE) begin
      rsp.read_data = {24'h0, 8'(word_rd >> byte_shift)};
    end else begin
      rsp.read_data = {16'h0, 16'(word_rd >> half_shift)};
    end
  end

endmodule

`default_nettype wire

// ===== design/analog_pll_register_block.sv =====
// ----------------------------------------------------------------------------
// analog_pll_register_block
// register file with write, set, clear and toggle aliases behind a bus port
// ----------------------------------------------------------------------------
// usage
//   req channel: one bus access word per handshake (cmd, offset, access_size,
//   write_data), taken at an edge with req_valid high and req_stall low
//   rsp channel: one result word per access (read_data, access_error), taken
//   at an edge with rsp_valid high and rsp_stall low
//   results: an access moves from the access stage into the result register
//   when it is free or being emptied; throughput: one access per cycle when
//   not stalled, reads and read-modify-writes alike; the register file ram
//   is read on the accept edge, written on entry to the result register; a
//   bypass register covers back-to-back accesses to one register
//   reset: clears the pipeline and the per-register written flags; a
//   register never written reads its power-on value from a constant table,
//   so there is no clearing pass and the block is ready right after reset
//   stall: while rsp_stall holds a waiting result, the access in flight
//   waits and req_stall rises in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

module analog_pll_register_block (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire apll_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output apll_pkg::rsp_t      rsp
);

  // access stage
  logic           s1_valid;
  apll_pkg::req_t s1_req;
  logic           advance;
  logic           accept;

  // register file and bypass
  logic [apll_pkg::IDX_W-1:0]     raddr;
  logic [apll_pkg::IDX_W-1:0]     s1_idx;
  logic [31:0]                    ram_rdata;
  logic [apll_pkg::REG_COUNT-1:0] written;
  logic                           fwd_valid;
  logic [apll_pkg::IDX_W-1:0]     fwd_idx;
  logic [31:0]                    fwd_data;
  logic [31:0]                    cur_word;

  apll_pkg::rsp_t alu_rsp;
  apll_pkg::wr_t  alu_wr;
  apll_pkg::wr_t  wr;

  // result register free or being emptied
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;
  assign accept    = req_valid && !req_stall;

  assign s1_idx = apll_pkg::slot_of(s1_req.offset);
  // a held access re-reads its own register so the ram data stays current
  assign raddr  = req_stall ? s1_idx : apll_pkg::slot_of(req.offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || advance) begin
      s1_valid <= req_valid;
    end
    if (accept) begin
      s1_req <= req;
    end
  end

  apll_ram #(
    .WIDTH (32),
    .DEPTH (apll_pkg::REG_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.idx),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // current register value: bypass of last edge's write, ram, or power-on value
  always_comb begin
    if (fwd_valid && (fwd_idx == s1_idx)) begin
      cur_word = fwd_data;
    end else if (written[s1_idx]) begin
      cur_word = ram_rdata;
    end else begin
      cur_word = apll_pkg::reset_value(s1_idx);
    end
  end

  apll_alu u_alu (
    .req      (s1_req),
    .cur_word (cur_word),
    .rsp      (alu_rsp),
    .wr       (alu_wr)
  );

  // commit only when the access moves into the result register
  always_comb begin
    wr    = alu_wr;
    wr.en = alu_wr.en && s1_valid && advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr.en;
      if (wr.en) begin
        written[wr.idx] <= 1'b1;
      end
    end
    fwd_idx  <= wr.idx;
    fwd_data <= wr.data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      rsp <= alu_rsp;
    end
  end

endmodule

`default_nettype wire

// ===== design/apll_checker.sv =====
// ----------------------------------------------------------------------------
// apll_checker
// port-level checks of the analog pll register block
// ----------------------------------------------------------------------------
`default_nettype none

module apll_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire apll_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire apll_pkg::rsp_t rsp
);

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // a rejected access never carries read data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.access_error |-> rsp.read_data == 32'h0)
    else $error("error result with nonzero read data");

  // every taken access is followed by a valid result word
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |-> ##2 rsp_valid)
    else $error("result word missing after accepted access");

  // the request side only waits on a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a held result");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind analog_pll_register_block apll_checker u_apll_checker (.*);

`default_nettype wire

// ===== tb/sv/analog_pll_register_block_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// analog_pll_register_block_tb
// self-checking bench for the pll register block: bus words go in through a
// queue-fed driver, a monitor predicts every access against its own copy of
// the register file and compares each reply word field by field
// ----------------------------------------------------------------------------

module analog_pll_register_block_tb;

  // size code three is handled as a word access
  localparam logic [1:0] SIZE_WIDE = 2'd3;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  apll_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  apll_pkg::rsp_t rsp;

  // pending bus words and the replies they are due to produce
  apll_pkg::req_t bus_words[$];
  apll_pkg::rsp_t due_replies[$];

  // shadow copy of the register file
  logic [31:0] shadow_regs[apll_pkg::REG_COUNT];

  // traffic shaping; the stimulus sets rates and hold request at falling edges
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  int error_count = 0;
  int quiet_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  analog_pll_register_block dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // ---------------------------------------------------------------- shadow model

  // power-on contents, per group
  function automatic logic [31:0] power_on_word(input int grp);
    case (grp)
      'h00: return 32'h8000_2042;
      'h01, 'h02: return 32'h8000_3000;
      'h03, 'h0E: return 32'h8000_2001;
      'h07: return 32'h0001_1006;
      'h08, 'h0B: return 32'h05F5_E100;
      'h09, 'h0C: return 32'h2964_619C;
      'h0A: return 32'h0001_100C;
      'h0F: return 32'h1311_100C;
      'h10: return 32'h1018_101B;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // word view of the aperture: id and zero locations shadow the file
  function automatic logic [31:0] fetch_word(input logic [11:0] off);
    if (off == apll_pkg::ID_OFFSET) return apll_pkg::ID_VALUE;
    if (off == apll_pkg::ZERO_OFFSET) return 32'h0;
    return shadow_regs[int'(off[11:4]) % apll_pkg::REG_COUNT];
  endfunction

  // word store through the write, set, clear and toggle aliases
  function automatic void store_word(input logic [11:0] off, input logic [31:0] v);
    logic [31:0] r;
    int slot;
    if (off == apll_pkg::ID_OFFSET || off == apll_pkg::ZERO_OFFSET) return;
    slot = int'(off[11:4]) % apll_pkg::REG_COUNT;
    r = shadow_regs[slot];
    case (off[3:2])
      apll_pkg::ALIAS_WRITE: r = v;
      apll_pkg::ALIAS_SET: r = r | v;
      apll_pkg::ALIAS_CLEAR: r = r & ~v;
      default: r = r ^ v;
    endcase
    // pll groups always report lock
    if (off[11:4] == 8'h00 || off[11:4] == 8'h01 || off[11:4] == 8'h02 ||
        off[11:4] == 8'h03 || off[11:4] == 8'h0E)
      r = r | apll_pkg::LOCK_BIT;
    shadow_regs[slot] = r;
  endfunction

  // one bus access against the shadow file, returns the reply it must give
  function automatic apll_pkg::rsp_t pll_bus_access(input apll_pkg::req_t a);
    apll_pkg::rsp_t r;
    logic [11:0] aligned;
    logic [31:0] mask;
    logic [31:0] merged;
    int sh;
    r = '0;
    aligned = {a.offset[11:2], 2'b00};
    sh = int'(a.offset[1:0]) * 8;
    if (a.access_size == apll_pkg::SIZE_WORD || a.access_size == SIZE_WIDE) begin
      if (a.offset[1:0] != 2'b00) begin
        r.access_error = 1'b1;
      end else if (a.cmd == apll_pkg::CMD_WRITE) begin
        store_word(a.offset, a.write_data);
      end else begin
        r.read_data = fetch_word(a.offset);
      end
    end else if (a.cmd == apll_pkg::CMD_WRITE) begin
      // merge first, upper bits of a half mask at byte three fall off
      mask = (a.access_size == apll_pkg::SIZE_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF;
      mask = mask << sh;
      merged = (fetch_word(aligned) & ~mask) | ((a.write_data << sh) & mask);
      store_word(aligned, merged);
    end else if (a.access_size == apll_pkg::SIZE_BYTE) begin
      r.read_data = (fetch_word(aligned) >> sh) & 32'h0000_00FF;
    end else begin
      r.read_data = (fetch_word(aligned) >> (int'(a.offset[1]) * 16)) & 32'h0000_FFFF;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic apll_pkg::req_t bus_word(input logic c, input logic [11:0] off,
                                              input logic [1:0] sz, input logic [31:0] d);
    apll_pkg::req_t a;
    a.cmd = c;
    a.offset = off;
    a.access_size = sz;
    a.write_data = d;
    return a;
  endfunction

  // hot groups (pll, id, zero, top) take half the picks so writes get read back
  function automatic apll_pkg::req_t random_word();
    apll_pkg::req_t a;
    int pick;
    logic [7:0] grp;
    pick = $urandom_range(99);
    if (pick < 50) begin
      case ($urandom_range(7))
        0, 1: grp = 8'($urandom_range(16));
        2: grp = 8'h26;
        3: grp = 8'h28;
        4: grp = 8'h0E;
        5: grp = 8'hFF;
        default: grp = 8'($urandom_range(3));
      endcase
    end else begin
      grp = 8'($urandom_range(255));
    end
    a.cmd = ($urandom_range(1) == 0) ? apll_pkg::CMD_READ : apll_pkg::CMD_WRITE;
    pick = $urandom_range(99);
    if (pick < 30) a.access_size = apll_pkg::SIZE_BYTE;
    else if (pick < 60) a.access_size = apll_pkg::SIZE_HALF;
    else if (pick < 95) a.access_size = apll_pkg::SIZE_WORD;
    else a.access_size = SIZE_WIDE;
    a.offset = {grp, 4'($urandom_range(15))};
    // word accesses are mostly aligned, the rest may hit the error path
    if (a.access_size[1] && $urandom_range(99) < 80) a.offset[1:0] = 2'b00;
    pick = $urandom_range(99);
    if (pick < 5) a.write_data = 32'h0;
    else if (pick < 10) a.write_data = 32'hFFFF_FFFF;
    else a.write_data = $urandom();
    return a;
  endfunction

  task automatic note_mismatch(input string what, input apll_pkg::rsp_t want,
                               input apll_pkg::rsp_t got);
    error_count++;
    if (error_count <= 10)
      $display("%0t %s: want read_data %h access_error %b, got read_data %h access_error %b",
               $time, what, want.read_data, want.access_error, got.read_data,
               got.access_error);
  endtask

  // ---------------------------------------------------------------- driver

  // a word stays on the bus until taken, idle gaps only start between words
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (bus_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req <= bus_words.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver side: random stall, plus one long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  // accepted words are predicted first, then the reply taken at this edge is
  // checked against the oldest prediction
  always @(posedge clk) begin : monitor_blk
    apll_pkg::rsp_t want;
    logic took_req;
    logic took_rsp;
    took_req = req_valid && !req_stall;
    took_rsp = rsp_valid && !rsp_stall;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (took_req) due_replies.push_back(pll_bus_access(req));
      if (took_rsp) begin
        if (due_replies.size() == 0) begin
          note_mismatch("reply with nothing due", '0, rsp);
        end else begin
          want = due_replies.pop_front();
          if (rsp.read_data !== want.read_data || rsp.access_error !== want.access_error)
            note_mismatch("reply mismatch", want, rsp);
        end
      end
      quiet_cycles <= (took_req || took_rsp) ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("analog_pll_register_block_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) bus_words.push_back(random_word());
    while (bus_words.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    for (int g = 0; g < apll_pkg::REG_COUNT; g++) shadow_regs[g] = power_on_word(g);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: power-on values, id and zero words
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'h000,
                                 apll_pkg::SIZE_WORD, 32'h0));
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'h100,
                                 apll_pkg::SIZE_WORD, 32'h0));
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, apll_pkg::ID_OFFSET,
                                 apll_pkg::SIZE_WORD, 32'h0));
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, apll_pkg::ZERO_OFFSET,
                                 apll_pkg::SIZE_WORD, 32'h0));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, apll_pkg::ID_OFFSET,
                                 apll_pkg::SIZE_WORD, 32'hFFFF_FFFF));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h281,
                                 apll_pkg::SIZE_BYTE, 32'hFFFF_FFFF));
    // sub-word reads near the id see the id word
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'h262,
                                 apll_pkg::SIZE_HALF, 32'h0));
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'h263,
                                 apll_pkg::SIZE_BYTE, 32'h0));
    // all four aliases on a plain register
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h040,
                                 apll_pkg::SIZE_WORD, 32'hA5A5_A5A5));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h044,
                                 apll_pkg::SIZE_WORD, 32'h0000_FFFF));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h048,
                                 apll_pkg::SIZE_WORD, 32'hFF00_FF00));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h04C,
                                 apll_pkg::SIZE_WORD, 32'hFFFF_FFFF));
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'h04C,
                                 apll_pkg::SIZE_WORD, 32'h0));
    // lock bit survives a zero write and a full clear
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h000,
                                 apll_pkg::SIZE_WORD, 32'h0));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h0E8,
                                 apll_pkg::SIZE_WORD, 32'hFFFF_FFFF));
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'h0E0,
                                 apll_pkg::SIZE_WORD, 32'h0));
    // merges, half write at byte three keeps only its low byte
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h043,
                                 apll_pkg::SIZE_BYTE, 32'hFFFF_FF5A));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h043,
                                 apll_pkg::SIZE_HALF, 32'h0000_1234));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h046,
                                 apll_pkg::SIZE_HALF, 32'hFFFF_8001));
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'h041,
                                 apll_pkg::SIZE_BYTE, 32'h0));
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'h043,
                                 apll_pkg::SIZE_HALF, 32'h0));
    // unaligned words, size code three, top of the aperture
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'h041,
                                 apll_pkg::SIZE_WORD, 32'h0));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h0E2,
                                 apll_pkg::SIZE_WORD, 32'hFFFF_FFFF));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'h050,
                                 SIZE_WIDE, 32'h1234_5678));
    bus_words.push_back(bus_word(apll_pkg::CMD_WRITE, 12'hFFF,
                                 apll_pkg::SIZE_BYTE, 32'hFFFF_FFFF));
    bus_words.push_back(bus_word(apll_pkg::CMD_READ, 12'hFFC,
                                 SIZE_WIDE, 32'h0));
    while (bus_words.size() != 0) @(negedge clk);

    // full rate, with the receiver holding off long enough to back up the block
    hold_request = 1'b1;
    run_random(400);

    send_idle_pct = 65;
    stall_pct = 0;
    run_random(350);

    send_idle_pct = 0;
    stall_pct = 65;
    run_random(400);

    send_idle_pct = 10;
    stall_pct = 10;
    run_random(400);

    send_idle_pct = 0;
    stall_pct = 0;
    run_random(200);

    // let the last words and their replies drain
    while (bus_words.size() != 0 || req_valid) @(negedge clk);
    while (due_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0 && due_replies.size() == 0)
      $display("analog_pll_register_block_tb: clean");
    else
      $display("analog_pll_register_block_tb: errors");
    $finish;
  end

endmodule
